// ----- rtl/core/sadu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadu_pkg: shared types for the sorted array insert/delete unit
// Request and response words, operation and status codes, and the tap
// that every cell shows to its neighbors.
// ----------------------------------------------------------------------------
package sadu_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = 5;

   typedef enum logic {
      SADU_OP_INSERT = 1'b0,
      SADU_OP_DELETE = 1'b1
   } sadu_op_type;

   typedef enum logic [1:0] {
      SADU_ST_DONE      = 2'd0,
      SADU_ST_FULL      = 2'd1,
      SADU_ST_EMPTY     = 2'd2,
      SADU_ST_NOT_FOUND = 2'd3
   } sadu_status_type;

   // request word
   typedef struct packed {
      sadu_op_type                   operation;
      logic signed [DATA_WIDTH-1:0]  value;
   } sadu_req_type;

   // response word
   typedef struct packed {
      sadu_status_type               status;
      logic [COUNT_WIDTH-1:0]        count;
   } sadu_rsp_type;

   // command broadcast to all cells
   typedef struct packed {
      logic                          ins_go;
      logic                          del_go;
      logic signed [DATA_WIDTH-1:0]  value;
   } sadu_cmd_type;

   // what a cell shows to its neighbors
   typedef struct packed {
      logic                          occ;   // holds an entry
      logic                          gt;    // entry greater than command value
      logic                          eq;    // entry equal to command value
      logic signed [DATA_WIDTH-1:0]  data;
   } sadu_tap_type;

endpackage

// ----- rtl/core/sadu_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadu_cell: one slot of the sorted chain
// Holds one entry, compares it to the broadcast value, and on a command
// takes the broadcast value, the lower neighbor's entry or the upper one's.
// ----------------------------------------------------------------------------
module sadu_cell (
   input  logic                  clock,
   input  logic                  occ,
   input  sadu_pkg::sadu_cmd_type cmd,
   input  sadu_pkg::sadu_tap_type below,
   input  sadu_pkg::sadu_tap_type above,
   output sadu_pkg::sadu_tap_type tap
);
   import sadu_pkg::*;

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         data_we;
   logic                         gt;
   logic                         eq;

   // compare against broadcast value
   assign gt = occ && (data_ff > cmd.value);
   assign eq = occ && (data_ff == cmd.value);

   assign tap.occ  = occ;
   assign tap.gt   = gt;
   assign tap.eq   = eq;
   assign tap.data = data_ff;

   // next entry: shift up on insert, shift down on delete
   always_comb begin
      data_we = 1'b0;
      data_in = data_ff;
      if (cmd.ins_go) begin
         if (below.gt) begin
            data_we = 1'b1;
            data_in = below.data;
         end else if (gt || (!occ && below.occ)) begin
            data_we = 1'b1;
            data_in = cmd.value;
         end
      end else if (cmd.del_go) begin
         // last equal entry is dropped and everything above it moves down
         if (gt || (eq && !above.eq)) begin
            data_we = 1'b1;
            data_in = above.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/core/sorted_array_insert_delete_unit.sv -----
`timescale 1ns / 1ps
// Response: the response word is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, every cell updates in
//   the same edge that takes the word, so the next word sees the new order.
// Reset: synchronous, clears the fill count and the response strobe; cell
//   contents are left as they are and only slots below the count are used.
// ----------------------------------------------------------------------------
// sorted_array_insert_delete_unit: sorted store with insert and delete
// A row of DEPTH compare-and-shift cells keeps signed values in ascending
// order; a fill count marks which cells hold entries.
// ----------------------------------------------------------------------------
module sorted_array_insert_delete_unit #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sadu_pkg::sadu_req_type req_word,
   output logic                  rsp_strobe,
   output sadu_pkg::sadu_rsp_type rsp_word
);
   import sadu_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_strobe_ff;
   sadu_rsp_type         rsp_word_ff;
   sadu_rsp_type         rsp_word_in;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 found;
   logic [DEPTH-1:0]     occ;
   logic [DEPTH-1:0]     eq_vec;
   sadu_cmd_type         cmd;
   sadu_tap_type         taps [DEPTH];
   sadu_tap_type         base_tap;
   sadu_tap_type         top_tap;

   // the chain takes a word every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign found = |eq_vec;

   // broadcast command
   always_comb begin
      cmd.value  = req_word.value;
      cmd.ins_go = accept && (req_word.operation == SADU_OP_INSERT) && !full;
      cmd.del_go = accept && (req_word.operation == SADU_OP_DELETE) && !empty
                   && found;
   end

   // chain ends: a virtual occupied smaller entry below, nothing above
   assign base_tap = '{occ: 1'b1, gt: 1'b0, eq: 1'b0, data: '0};
   assign top_tap  = '{occ: 1'b0, gt: 1'b0, eq: 1'b0, data: '0};

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i]    = (CNT_W'(i) < count_ff);
      assign eq_vec[i] = taps[i].eq;
      sadu_cell u_cell (
         .clock (clock),
         .occ   (occ[i]),
         .cmd   (cmd),
         .below ((i == 0) ? base_tap : taps[(i == 0) ? 0 : i - 1]),
         .above ((i == DEPTH - 1) ? top_tap : taps[(i == DEPTH - 1) ? i : i + 1]),
         .tap   (taps[i])
      );
   end

   // count and status
   always_comb begin
      count_in           = count_ff;
      rsp_word_in.status = SADU_ST_DONE;
      if (req_word.operation == SADU_OP_INSERT) begin
         if (full) begin
            rsp_word_in.status = SADU_ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            rsp_word_in.status = SADU_ST_EMPTY;
         end else if (!found) begin
            rsp_word_in.status = SADU_ST_NOT_FOUND;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      rsp_word_in.count = COUNT_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response strobe missing after accept");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("fill count moved without a request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.ins_go || cmd.del_go) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("fill count did not step by one");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !cmd.ins_go && !cmd.del_go) |=> $stable(count_ff))
      else $error("rejected request changed the count");

endmodule
